// ===== design/tod_pkg.sv =====
// ----------------------------------------------------------------------------
// tod_pkg
// Shared widths, command codes, queue word layout and divide-by-constant
// helpers for the time of day counter.
// ----------------------------------------------------------------------------
package tod_pkg;

  localparam int CMD_W    = 3;
  localparam int RAW_W    = 8;
  localparam int AMT_W    = 20;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;

  localparam int MIN_LEN   = 60;
  localparam int DAY_HOURS = 24;
  localparam int LAST_MIN  = 59;
  localparam int LAST_HOUR = 23;

  // reciprocal of 60, exact floor for any 20-bit dividend
  localparam int RECIP60_SHIFT = 26;
  localparam logic [20:0] RECIP60 = 21'd1118482;
  // reciprocal of 24, exact floor for any 9-bit dividend
  localparam int RECIP24_SHIFT = 14;
  localparam logic [9:0] RECIP24 = 10'd683;

  localparam logic [CMD_W-1:0] CMD_SET  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FWD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BACK = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd4;

  typedef logic [1:0] op_t;
  localparam op_t OP_HOLD = 2'd0;
  localparam op_t OP_LOAD = 2'd1;
  localparam op_t OP_ADD  = 2'd2;

  typedef struct packed {
    op_t               op;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } tod_entry_t;

  typedef struct packed {
    logic       valid;
    tod_entry_t entry;
  } tod_word_t;

  function automatic logic [14:0] div60(input logic [AMT_W-1:0] x);
    logic [40:0] p;
    p = 41'(x) * 41'(RECIP60);
    return p[40:RECIP60_SHIFT];
  endfunction

  function automatic logic [4:0] div24(input logic [8:0] x);
    logic [18:0] p;
    p = 19'(x) * 19'(RECIP24);
    return p[18:RECIP24_SHIFT];
  endfunction

endpackage

// ===== design/tod_in_if.sv =====
// ----------------------------------------------------------------------------
// tod_in_if
// Command channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface tod_in_if;
  logic                       valid;
  logic                       ready;
  logic [tod_pkg::CMD_W-1:0]  cmd;
  logic [tod_pkg::RAW_W-1:0]  set_hour;
  logic [tod_pkg::RAW_W-1:0]  set_minute;
  logic [tod_pkg::RAW_W-1:0]  set_second;
  logic [tod_pkg::AMT_W-1:0]  amount;

  modport source (output valid, cmd, set_hour, set_minute, set_second, amount,
                  input ready);
  modport sink   (input valid, cmd, set_hour, set_minute, set_second, amount,
                  output ready);
endinterface

// ===== design/tod_out_if.sv =====
// ----------------------------------------------------------------------------
// tod_out_if
// Result channel: valid/ready handshake carrying the time after a command.
// ----------------------------------------------------------------------------
interface tod_out_if;
  logic                       valid;
  logic                       ready;
  logic [tod_pkg::HOUR_W-1:0] hour_now;
  logic [tod_pkg::MIN_W-1:0]  minute_now;
  logic [tod_pkg::SEC_W-1:0]  second_now;

  modport source (output valid, hour_now, minute_now, second_now, input ready);
  modport sink   (input valid, hour_now, minute_now, second_now, output ready);
endinterface

// ===== design/tod_front.sv =====
// ----------------------------------------------------------------------------
// tod_front
// Accepts commands and turns each into a queue word: an absolute time for
// set, or an hh:mm:ss offset for the stepping and add/subtract commands.
// Three register stages split the base-60/60/24 decomposition.
// ----------------------------------------------------------------------------
module tod_front (
  input  logic               clk,
  input  logic               rst_n,
  tod_in_if.sink             in_port,
  output tod_pkg::tod_word_t push,
  input  logic               q_full
);

  // stage a: raw command
  logic                          a_v_r;
  logic [tod_pkg::CMD_W-1:0]     a_cmd_r;
  logic [tod_pkg::RAW_W-1:0]     a_sh_r, a_sm_r, a_ss_r;
  logic [tod_pkg::AMT_W-1:0]     a_amt_r;
  // stage b: seconds split off
  logic                          b_v_r;
  logic [tod_pkg::CMD_W-1:0]     b_cmd_r;
  logic [tod_pkg::RAW_W-1:0]     b_sh_r, b_sm_r;
  logic [14:0]                   b_q_r;
  logic [tod_pkg::SEC_W-1:0]     b_s_r;
  // stage c: minutes split off
  logic                          c_v_r;
  logic [tod_pkg::CMD_W-1:0]     c_cmd_r;
  logic [tod_pkg::RAW_W-1:0]     c_sh_r;
  logic [8:0]                    c_q_r;
  logic [tod_pkg::MIN_W-1:0]     c_m_r;
  logic [tod_pkg::SEC_W-1:0]     c_s_r;

  logic a_ready, b_ready, c_ready;

  assign c_ready = !c_v_r || !q_full;
  assign b_ready = !b_v_r || c_ready;
  assign a_ready = !a_v_r || b_ready;
  assign in_port.ready = a_ready;

  // stage b arithmetic
  logic [tod_pkg::AMT_W-1:0] b_x;
  logic [14:0]               b_q_nxt;
  logic [20:0]               b_q60;
  logic [20:0]               b_rem;

  always_comb begin
    b_x     = (a_cmd_r == tod_pkg::CMD_SET) ? {12'd0, a_ss_r} : a_amt_r;
    b_q_nxt = tod_pkg::div60(b_x);
    b_q60   = {b_q_nxt, 6'd0} - {4'd0, b_q_nxt, 2'd0};
    b_rem   = {1'b0, b_x} - b_q60;
  end

  // stage c arithmetic
  logic [15:0] c_y;
  logic [14:0] c_qfull;
  logic [8:0]  c_q_nxt;
  logic [14:0] c_q60;
  logic [15:0] c_rem;

  always_comb begin
    c_y     = {1'b0, b_q_r} + ((b_cmd_r == tod_pkg::CMD_SET) ? {8'd0, b_sm_r} : 16'd0);
    c_qfull = tod_pkg::div60({4'd0, c_y});
    c_q_nxt = c_qfull[8:0];
    c_q60   = {c_q_nxt, 6'd0} - {4'd0, c_q_nxt, 2'd0};
    c_rem   = c_y - {1'b0, c_q60};
  end

  // stage d arithmetic, feeds the queue directly
  logic [8:0]                z;
  logic [4:0]                hq;
  logic [8:0]                hq24;
  logic [8:0]                hrem;
  logic [tod_pkg::HOUR_W-1:0] h;
  logic [tod_pkg::SEC_W-1:0]  ns;
  logic [6:0]                 mb;
  logic [tod_pkg::MIN_W-1:0]  nm;
  logic [5:0]                 hb;
  logic [tod_pkg::HOUR_W-1:0] nh;
  logic                       b1, b2;

  always_comb begin
    z    = c_q_r + ((c_cmd_r == tod_pkg::CMD_SET) ? {1'b0, c_sh_r} : 9'd0);
    hq   = tod_pkg::div24(z);
    hq24 = {hq, 4'd0} + {1'b0, hq, 3'd0};
    hrem = z - hq24;
    h    = hrem[tod_pkg::HOUR_W-1:0];
    // mixed-radix negate for subtract
    b1 = (c_s_r != '0);
    ns = b1 ? 6'(tod_pkg::MIN_LEN - 32'(c_s_r)) : '0;
    mb = {1'b0, c_m_r} + {6'd0, b1};
    b2 = (mb != '0);
    nm = (mb == 7'(tod_pkg::MIN_LEN) || !b2) ? '0 : 6'(7'(tod_pkg::MIN_LEN) - mb);
    hb = {1'b0, h} + {5'd0, b2};
    nh = (hb == 6'(tod_pkg::DAY_HOURS) || hb == '0) ? '0
                                                     : 5'(6'(tod_pkg::DAY_HOURS) - hb);
  end

  always_comb begin
    push.valid = c_v_r;
    unique case (c_cmd_r)
      tod_pkg::CMD_SET:  push.entry = '{tod_pkg::OP_LOAD, h, c_m_r, c_s_r};
      tod_pkg::CMD_FWD:  push.entry = '{tod_pkg::OP_ADD, '0, '0, 6'd1};
      tod_pkg::CMD_BACK: push.entry = '{tod_pkg::OP_ADD, 5'(tod_pkg::LAST_HOUR),
                                        6'(tod_pkg::LAST_MIN), 6'(tod_pkg::LAST_MIN)};
      tod_pkg::CMD_ADD:  push.entry = '{tod_pkg::OP_ADD, h, c_m_r, c_s_r};
      tod_pkg::CMD_SUB:  push.entry = '{tod_pkg::OP_ADD, nh, nm, ns};
      default:           push.entry = '{tod_pkg::OP_HOLD, '0, '0, '0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      if (a_ready) a_v_r <= in_port.valid;
      if (b_ready) b_v_r <= a_v_r;
      if (c_ready) c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_cmd_r <= in_port.cmd;
      a_sh_r  <= in_port.set_hour;
      a_sm_r  <= in_port.set_minute;
      a_ss_r  <= in_port.set_second;
      a_amt_r <= in_port.amount;
    end
    if (b_ready) begin
      b_cmd_r <= a_cmd_r;
      b_sh_r  <= a_sh_r;
      b_sm_r  <= a_sm_r;
      b_q_r   <= b_q_nxt;
      b_s_r   <= b_rem[tod_pkg::SEC_W-1:0];
    end
    if (c_ready) begin
      c_cmd_r <= b_cmd_r;
      c_sh_r  <= b_sh_r;
      c_q_r   <= c_q_nxt;
      c_m_r   <= c_rem[tod_pkg::MIN_W-1:0];
      c_s_r   <= b_s_r;
    end
  end

endmodule

// ===== design/tod_queue.sv =====
// ----------------------------------------------------------------------------
// tod_queue
// Two-entry queue of decoded words between the front and back parts.
// ----------------------------------------------------------------------------
module tod_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  tod_pkg::tod_word_t push,
  output logic               full,
  output tod_pkg::tod_word_t head,
  input  logic               pop
);

  tod_pkg::tod_entry_t mem_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          count_r;
  logic                do_push;

  assign full       = (count_r == 2'd2);
  assign do_push    = push.valid && !full;
  assign head.valid = (count_r != 2'd0);
  assign head.entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (pop)     rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.entry;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0) else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !pop |=> count_r == $past(count_r) + 2'd1)
    else $error("queue count missed a push");

endmodule

// ===== design/tod_back.sv =====
// ----------------------------------------------------------------------------
// tod_back
// Holds the time of day in its result registers; unless the receiver stalls,
// applies one queue word per cycle: load, add hh:mm:ss with carries, or hold.
// ----------------------------------------------------------------------------
module tod_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tod_pkg::tod_word_t head,
  output logic               pop,
  tod_out_if.source          out_port
);

  logic [tod_pkg::HOUR_W-1:0] hour_r, hour_nxt;
  logic [tod_pkg::MIN_W-1:0]  minute_r, minute_nxt;
  logic [tod_pkg::SEC_W-1:0]  second_r, second_nxt;
  logic                       out_valid_r;

  logic [6:0] s_sum, m_sum;
  logic [5:0] h_sum;
  logic       c1, c2;

  assign pop = head.valid && (!out_valid_r || out_port.ready);

  always_comb begin
    s_sum = {1'b0, second_r} + {1'b0, head.entry.second};
    c1    = (s_sum >= 7'(tod_pkg::MIN_LEN));
    m_sum = {1'b0, minute_r} + {1'b0, head.entry.minute} + {6'd0, c1};
    c2    = (m_sum >= 7'(tod_pkg::MIN_LEN));
    h_sum = {1'b0, hour_r} + {1'b0, head.entry.hour} + {5'd0, c2};
    unique case (head.entry.op)
      tod_pkg::OP_LOAD: begin
        hour_nxt   = head.entry.hour;
        minute_nxt = head.entry.minute;
        second_nxt = head.entry.second;
      end
      tod_pkg::OP_ADD: begin
        second_nxt = c1 ? 6'(s_sum - 7'(tod_pkg::MIN_LEN)) : s_sum[5:0];
        minute_nxt = c2 ? 6'(m_sum - 7'(tod_pkg::MIN_LEN)) : m_sum[5:0];
        hour_nxt   = (h_sum >= 6'(tod_pkg::DAY_HOURS))
                     ? 5'(h_sum - 6'(tod_pkg::DAY_HOURS)) : h_sum[4:0];
      end
      default: begin
        hour_nxt   = hour_r;
        minute_nxt = minute_r;
        second_nxt = second_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r      <= '0;
      minute_r    <= '0;
      second_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
        second_r <= second_nxt;
      end
      if (pop) out_valid_r <= 1'b1;
      else if (out_port.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_port.valid      = out_valid_r;
  assign out_port.hour_now   = hour_r;
  assign out_port.minute_now = minute_r;
  assign out_port.second_now = second_r;

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    hour_r < 5'(tod_pkg::DAY_HOURS) && minute_r < 6'(tod_pkg::MIN_LEN)
      && second_r < 6'(tod_pkg::MIN_LEN)) else $error("time out of range");
  a_load_value: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head.entry.op == tod_pkg::OP_LOAD |=> hour_r == $past(head.entry.hour)
      && minute_r == $past(head.entry.minute)) else $error("load not applied");
  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    !pop |=> $stable(hour_r) && $stable(minute_r) && $stable(second_r))
    else $error("time changed without a queue word");

endmodule

// ===== design/time_of_day_counter.sv =====
// ----------------------------------------------------------------------------
// time_of_day_counter
// 24-hour time of day counter driven by a command stream.
// in_port carries one command word (set, step forward, step back, add or
// subtract seconds); out_port returns the hh:mm:ss time after each command,
// one result word per command, in order.
// Each accepted command passes through three front stages, which split raw
// values and amounts into hours, minutes and seconds with reciprocal
// multiplies, then through the queue; the back part then applies the word to
// the time registers with a combinational carry add. One command is
// accepted per cycle while the receiver is ready.
// A two-word queue parts the front from the back; when the receiver stalls
// the back waits on its output register, the queue fills and in_port.ready
// falls once the front stages are full. Reset clears the time to 00:00:00
// and empties every stage.
// ----------------------------------------------------------------------------
module time_of_day_counter (
  input  logic      clk,
  input  logic      rst_n,
  tod_in_if.sink    in_port,
  tod_out_if.source out_port
);

  tod_pkg::tod_word_t push;
  tod_pkg::tod_word_t head;
  logic               q_full;
  logic               pop;

  tod_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_port (in_port),
    .push    (push),
    .q_full  (q_full)
  );

  tod_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  tod_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_port (out_port)
  );

endmodule

// ===== sim/tb_time_of_day_counter.sv =====
// ----------------------------------------------------------------------------
// tb_time_of_day_counter
// Self-checking bench for the time of day counter. Commands go in through
// in_port with random gaps and the time words coming back on out_port are
// compared against a running hh:mm:ss model kept in a small scoreboard.
// Directed words cover midnight wraps, raw maxima and extreme amounts, then
// about two thousand random words run under changing backpressure.
// ----------------------------------------------------------------------------
module tb_time_of_day_counter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_W        = tod_pkg::CMD_W;
  localparam int RAW_W        = tod_pkg::RAW_W;
  localparam int AMT_W        = tod_pkg::AMT_W;
  localparam int HOUR_W       = tod_pkg::HOUR_W;
  localparam int MIN_W        = tod_pkg::MIN_W;
  localparam int SEC_W        = tod_pkg::SEC_W;
  localparam int HOUR_SECS    = tod_pkg::MIN_LEN * tod_pkg::MIN_LEN;
  localparam int DAY_SECS     = tod_pkg::DAY_HOURS * HOUR_SECS;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS = 2000;
  localparam int HOLD_AT      = 1100;
  localparam int HOLD_CYCLES  = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 12;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } clock_time_t;

  class tod_scoreboard;
    clock_time_t now;
    clock_time_t expected_q[$];
    int errors;
    int checked;
    int sets;
    int steps;
    int shifts;
    int spares;

    function new();
      now = '0;
    endfunction

    function void load_total(input int unsigned t);
      int unsigned day_t;
      day_t = t % DAY_SECS;
      now.hour   = HOUR_W'(day_t / HOUR_SECS);
      now.minute = MIN_W'((day_t / tod_pkg::MIN_LEN) % tod_pkg::MIN_LEN);
      now.second = SEC_W'(day_t % tod_pkg::MIN_LEN);
    endfunction

    function void note_command(input logic [CMD_W-1:0] cmd, input logic [RAW_W-1:0] sh,
                               input logic [RAW_W-1:0] sm, input logic [RAW_W-1:0] ss,
                               input logic [AMT_W-1:0] amt);
      int unsigned total;
      int unsigned shift;
      int unsigned h;
      int unsigned m;
      int unsigned s;
      total = now.hour * HOUR_SECS + now.minute * tod_pkg::MIN_LEN + now.second;
      shift = amt % DAY_SECS;
      case (cmd)
        tod_pkg::CMD_SET: begin
          s = ss;
          m = sm + s / tod_pkg::MIN_LEN;
          s = s % tod_pkg::MIN_LEN;
          h = sh + m / tod_pkg::MIN_LEN;
          m = m % tod_pkg::MIN_LEN;
          h = h % tod_pkg::DAY_HOURS;
          now.hour   = HOUR_W'(h);
          now.minute = MIN_W'(m);
          now.second = SEC_W'(s);
          sets++;
        end
        tod_pkg::CMD_FWD: begin
          load_total(total + 1);
          steps++;
        end
        tod_pkg::CMD_BACK: begin
          load_total(total + DAY_SECS - 1);
          steps++;
        end
        tod_pkg::CMD_ADD: begin
          load_total(total + shift);
          shifts++;
        end
        tod_pkg::CMD_SUB: begin
          load_total(total + DAY_SECS - shift);
          shifts++;
        end
        default: begin
          spares++;
        end
      endcase
      expected_q.push_back(now);
    endfunction

    function void check_time(input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m,
                             input logic [SEC_W-1:0] s);
      clock_time_t want;
      checked++;
      if (expected_q.size() == 0) begin
        $error("time word %0d:%0d:%0d with no command pending", h, m, s);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (h !== want.hour) begin
        $error("hour_now: expected %0d, actual %0d", want.hour, h);
        errors++;
      end
      if (m !== want.minute) begin
        $error("minute_now: expected %0d, actual %0d", want.minute, m);
        errors++;
      end
      if (s !== want.second) begin
        $error("second_now: expected %0d, actual %0d", want.second, s);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   in_steady;
  bit   out_steady;

  tod_in_if  in_port();
  tod_out_if out_port();

  tod_scoreboard sb = new();

  time_of_day_counter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_port),
    .out_port (out_port)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [RAW_W-1:0] sh,
                          input logic [RAW_W-1:0] sm, input logic [RAW_W-1:0] ss,
                          input logic [AMT_W-1:0] amt);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_port.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_port.valid      <= 1'b1;
    in_port.cmd        <= cmd;
    in_port.set_hour   <= sh;
    in_port.set_minute <= sm;
    in_port.set_second <= ss;
    in_port.amount     <= amt;
    do @(posedge clk); while (!(in_port.valid === 1'b1 && in_port.ready === 1'b1));
    sb.note_command(cmd, sh, sm, ss, amt);
  endtask

  task automatic send_random_word();
    logic [CMD_W-1:0] cmd;
    logic [RAW_W-1:0] sh;
    logic [RAW_W-1:0] sm;
    logic [RAW_W-1:0] ss;
    logic [AMT_W-1:0] amt;
    if ($urandom_range(0, 9) == 0) begin
      cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end else begin
      cmd = CMD_W'($urandom_range(tod_pkg::CMD_SET, tod_pkg::CMD_SUB));
    end
    sh = RAW_W'($urandom);
    sm = RAW_W'($urandom);
    ss = RAW_W'($urandom);
    // park near a boundary now and then so single steps cross it
    if (cmd == tod_pkg::CMD_SET && $urandom_range(0, 1) == 1) begin
      sh = $urandom_range(0, 1) ? RAW_W'(tod_pkg::LAST_HOUR) : '0;
      sm = $urandom_range(0, 1) ? RAW_W'(tod_pkg::LAST_MIN) : '0;
      ss = RAW_W'($urandom_range(tod_pkg::LAST_MIN - 4, tod_pkg::LAST_MIN));
    end
    case ($urandom_range(0, 3))
      0: amt = AMT_W'($urandom);
      1: amt = AMT_W'($urandom_range(0, 2 * tod_pkg::MIN_LEN));
      2: amt = AMT_W'(DAY_SECS * $urandom_range(1, 12) - $urandom_range(0, 1));
      default: amt = AMT_W'($urandom_range(HOUR_SECS - 100, HOUR_SECS + 100));
    endcase
    send_cmd(cmd, sh, sm, ss, amt);
  endtask

  // result side
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_port.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!held && sb.checked >= HOLD_AT) begin
        gap  = HOLD_CYCLES;
        held = 1'b1;
      end else begin
        gap = out_steady ? 0 : $urandom_range(0, 4);
      end
      if (gap > 0) begin
        out_port.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_port.ready <= 1'b1;
      do @(posedge clk); while (!(out_port.valid === 1'b1 && out_port.ready === 1'b1));
      sb.check_time(out_port.hour_now, out_port.minute_now, out_port.second_now);
    end
  end

  // watchdog on cycles where no word moves
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_port.valid === 1'b1 && in_port.ready === 1'b1) ||
          (out_port.valid === 1'b1 && out_port.ready === 1'b1)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("no word moved for %0d cycles, giving up", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_port.valid      <= 1'b0;
    in_port.cmd        <= tod_pkg::CMD_SET;
    in_port.set_hour   <= '0;
    in_port.set_minute <= '0;
    in_port.set_second <= '0;
    in_port.amount     <= '0;
    in_steady  = 1'b0;
    out_steady = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // midnight wraps from the reset time
    send_cmd(tod_pkg::CMD_BACK, '0, '0, '0, '0);
    send_cmd(tod_pkg::CMD_FWD, '1, '1, '1, '1);
    // raw set values at their extremes and at the carry points
    send_cmd(tod_pkg::CMD_SET, '1, '1, '1, '0);
    send_cmd(tod_pkg::CMD_SET, '0, '0, '0, '1);
    send_cmd(tod_pkg::CMD_SET, RAW_W'(tod_pkg::DAY_HOURS), RAW_W'(tod_pkg::MIN_LEN),
             RAW_W'(tod_pkg::MIN_LEN), '0);
    send_cmd(tod_pkg::CMD_SET, RAW_W'(tod_pkg::LAST_HOUR), RAW_W'(tod_pkg::LAST_MIN),
             RAW_W'(tod_pkg::LAST_MIN), '0);
    send_cmd(tod_pkg::CMD_FWD, '0, '0, '0, '0);
    // add and subtract across midnight and with extreme amounts
    send_cmd(tod_pkg::CMD_SUB, '0, '0, '0, AMT_W'(10));
    send_cmd(tod_pkg::CMD_ADD, '0, '0, '0, AMT_W'(15));
    send_cmd(tod_pkg::CMD_ADD, '0, '0, '0, '1);
    send_cmd(tod_pkg::CMD_SUB, '0, '0, '0, '1);
    send_cmd(tod_pkg::CMD_ADD, '0, '0, '0, AMT_W'(DAY_SECS));
    send_cmd(tod_pkg::CMD_SUB, '0, '0, '0, AMT_W'(DAY_SECS - 1));
    send_cmd(tod_pkg::CMD_ADD, '0, '0, '0, AMT_W'(DAY_SECS - 1));
    send_cmd(tod_pkg::CMD_SUB, '1, '1, '1, '0);
    // unused codes hold the time
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
      send_cmd(CMD_W'(c), '1, '1, '1, '1);
    end
    send_cmd(tod_pkg::CMD_BACK, RAW_W'($urandom), RAW_W'($urandom), RAW_W'($urandom),
             AMT_W'($urandom));

    // random phases: both idle, neither idles, one side steady at a time
    for (int seg = 0; seg < 4; seg++) begin
      in_steady  = (seg == 1 || seg == 2);
      out_steady = (seg == 1 || seg == 3);
      repeat (RANDOM_WORDS / 4) send_random_word();
    end
    in_port.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d commands: %0d set, %0d single steps, %0d add/subtract, %0d unused",
             sb.sets + sb.steps + sb.shifts + sb.spares, sb.sets, sb.steps, sb.shifts,
             sb.spares);
    $display("checked %0d time words, %0d field errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tod_pkg.sv
design/tod_in_if.sv
design/tod_out_if.sv
design/tod_front.sv
design/tod_queue.sv
design/tod_back.sv
design/time_of_day_counter.sv
sim/tb_time_of_day_counter.sv
